// ----- rtl/core/qam_pkg.sv -----
// ----------------------------------------------------------------------------
// qam_pkg
// Shared types, constants and the constellation level lookup for the
// hard-decision QAM demapper.
// ----------------------------------------------------------------------------
package qam_pkg;

   // Sample and result widths
   localparam int SAMPLE_W = 16;
   localparam int DIST_W   = 16;
   localparam int BITS_W   = 8;
   localparam int MODE_W   = 2;
   localparam int AXIS_W   = 4;   // bits per axis at 256-QAM
   localparam int MUL_W    = 17;  // operand width of the shared multiplier
   localparam int PROD_W   = 2 * MUL_W;
   localparam int SUM_W    = 32;  // distance accumulator and squared distance
   localparam int BIT_W    = 5;   // trial bit counter for root and quotient
   localparam int LEVEL_W  = 14;

   localparam int MAX_BURST_DEF = 65536;

   // Constellation select
   localparam logic [MODE_W-1:0] MODE_QPSK   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QAM16  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QAM64  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_QAM256 = 2'd3;

   // Level magnitudes in unsigned Q1.13, already scaled by the mode's normalization
   localparam logic [LEVEL_W-1:0] LEVEL_TBL [4][8] = '{
      '{14'd5793, 14'd0,    14'd0,    14'd0,    14'd0,    14'd0,    14'd0,    14'd0},
      '{14'd2591, 14'd7772, 14'd0,    14'd0,    14'd0,    14'd0,    14'd0,    14'd0},
      '{14'd1264, 14'd3792, 14'd6320, 14'd8848, 14'd0,    14'd0,    14'd0,    14'd0},
      '{14'd628,  14'd1885, 14'd3141, 14'd4398, 14'd5655, 14'd6911, 14'd8168, 14'd9424}
   };

   // Highest per-axis bit pattern for each mode
   localparam logic [AXIS_W-1:0] LAST_CAND [4] = '{4'd1, 4'd3, 4'd7, 4'd15};

   // Trial bit where the root and quotient searches start
   localparam logic [BIT_W-1:0] SQRT_TOP_BIT = 5'd15;
   localparam logic [BIT_W-1:0] DIV_TOP_BIT  = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SQRT,
      ST_DIV,
      ST_DONE
   } state_type;

   // Signed Q2.13 coordinate of one axis; abits holds c0 as its MSB
   function automatic logic signed [SAMPLE_W-1:0] axis_level(
      input logic [MODE_W-1:0] mode,
      input logic [AXIS_W-1:0] abits
   );
      int k;
      int m;
      int s;
      logic [LEVEL_W-1:0] mag;
      logic signed [SAMPLE_W-1:0] lvl;
      k = int'(mode) + 1;
      m = 1;
      if (k > 1) begin
         s = 1 - 2 * int'(abits[0]);
         m = 2 - s;
         for (int t = 1; t <= 2; t++) begin
            if (t <= k - 2) begin
               s = 1 - 2 * int'(abits[t]);
               m = (1 << (t + 1)) - s * m;
            end
         end
      end
      mag = LEVEL_TBL[mode][3'((m - 1) >> 1)];
      lvl = $signed({2'b00, mag});
      return abits[mode] ? -lvl : lvl;
   endfunction

endpackage

// ----- rtl/core/qam_hard_demapper.sv -----
// ----------------------------------------------------------------------------
// qam_hard_demapper
// Hard-decision demapper for QPSK, 16-, 64- and 256-QAM with error distance
// and per-burst mean error.
// ----------------------------------------------------------------------------
// One symbol is handled at a time by a single 17x17 multiply-and-compare
// unit under a small sequencer. The unit first scans every level of the I
// axis and then every level of the Q axis, then finds the 16-bit square
// root of the squared error one bit per cycle, and on a burst's last symbol
// finds the mean by a 17-bit trial-multiply division. A done state then
// hands the result over, and the idle state takes the next sample.
// req_tready is high only between symbols. The result sits in an output
// register, so the next sample is taken while it waits. qam_mode must be
// written through the csr port only while the block is idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module qam_hard_demapper
   import qam_pkg::*;
#(
   parameter int MAX_BURST = MAX_BURST_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration: qam_mode
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data,
   // Sample input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // i_sample[15:0], q_sample[31:16]
   input  logic        req_tlast,   // burst_end
   // Result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // bits[7:0], error_distance[23:8],
                                    // average_distance[39:24]
   output logic        rsp_tlast    // last_out
);

   localparam int CNT_W = $clog2(MAX_BURST + 1);

   // Registers and next values
   state_type                  state_ff,    state_in;
   logic [MODE_W-1:0]          mode_ff,     mode_in;
   logic signed [SAMPLE_W-1:0] i_ff,        i_in;
   logic signed [SAMPLE_W-1:0] q_ff,        q_in;
   logic                       last_ff,     last_in;
   logic                       axis_ff,     axis_in;
   logic [AXIS_W-1:0]          cand_ff,     cand_in;
   logic [SUM_W-1:0]           best_ff,     best_in;
   logic [AXIS_W-1:0]          best_idx_ff, best_idx_in;
   logic [AXIS_W-1:0]          ib_ff,       ib_in;
   logic [SUM_W-1:0]           di2_ff,      di2_in;
   logic [SUM_W-1:0]           d2_ff,       d2_in;
   logic [DIST_W-1:0]          root_ff,     root_in;
   logic [BIT_W-1:0]           bit_ff,      bit_in;
   logic [SUM_W-1:0]           sum_ff,      sum_in;
   logic [CNT_W-1:0]           cnt_ff,      cnt_in;
   logic [MUL_W-1:0]           quo_ff,      quo_in;
   logic [DIST_W-1:0]          avg_ff,      avg_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [39:0]                rsp_data_ff,  rsp_data_in;
   logic                       rsp_last_ff,  rsp_last_in;

   // Shared unit
   logic [MUL_W-1:0]           op_a, op_b;
   logic [PROD_W-1:0]          prod;
   logic [SUM_W-1:0]           cmp_ref;
   logic                       prod_le;

   // Scan datapath
   logic signed [SAMPLE_W-1:0] level;
   logic signed [SAMPLE_W-1:0] sample_sel;
   logic signed [MUL_W-1:0]    diff;
   logic [MUL_W-1:0]           diff_abs;
   logic                       cand_last;
   logic [SUM_W-1:0]           axis_best;
   logic [AXIS_W-1:0]          axis_best_idx;

   // Root and quotient trial values
   logic [DIST_W-1:0]          root_try;
   logic [DIST_W-1:0]          root_fin;
   logic [MUL_W-1:0]           quo_try;

   // Accumulator update
   logic [SUM_W:0]             sum_add;
   logic [BITS_W-1:0]          bits_out;

   // Level distance for the current candidate
   always_comb begin
      level      = axis_level(mode_ff, cand_ff);
      sample_sel = axis_ff ? q_ff : i_ff;
      diff       = {sample_sel[SAMPLE_W-1], sample_sel} - {level[SAMPLE_W-1], level};
      diff_abs   = diff[MUL_W-1] ? MUL_W'(-diff) : MUL_W'(diff);
      cand_last  = (cand_ff == LAST_CAND[mode_ff]);
   end

   assign root_try = root_ff | (DIST_W'(1) << bit_ff[3:0]);
   assign quo_try  = quo_ff | (MUL_W'(1) << bit_ff);

   // Operand select for the shared multiply-and-compare unit
   always_comb begin
      case (state_ff)
         ST_SQRT: begin
            op_a    = MUL_W'(root_try);
            op_b    = MUL_W'(root_try);
            cmp_ref = d2_ff;
         end
         ST_DIV: begin
            op_a    = quo_try;
            op_b    = MUL_W'(cnt_ff);
            cmp_ref = sum_ff;
         end
         default: begin
            op_a    = diff_abs;
            op_b    = diff_abs;
            cmp_ref = best_ff;
         end
      endcase
   end

   assign prod    = op_a * op_b;
   assign prod_le = (prod <= PROD_W'(cmp_ref));

   // Best of this axis including the current candidate (ties: higher pattern)
   assign axis_best     = prod_le ? prod[SUM_W-1:0] : best_ff;
   assign axis_best_idx = prod_le ? cand_ff : best_idx_ff;

   // Root with this cycle's bit decided; complete on the last root cycle
   assign root_fin = prod_le ? root_try : root_ff;
   assign sum_add  = {1'b0, sum_ff} + (SUM_W + 1)'(root_fin);

   // Interleave the axis patterns: I bits on odd, Q bits on even positions
   always_comb begin
      for (int m = 0; m < AXIS_W; m++) begin
         bits_out[2*m+1] = ib_ff[m];
         bits_out[2*m]   = best_idx_ff[m];
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      i_in         = i_ff;
      q_in         = q_ff;
      last_in      = last_ff;
      axis_in      = axis_ff;
      cand_in      = cand_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      ib_in        = ib_ff;
      di2_in       = di2_ff;
      d2_in        = d2_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      quo_in       = quo_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      // Configuration write
      if (csr_valid) begin
         mode_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               i_in     = $signed(req_tdata[15:0]);
               q_in     = $signed(req_tdata[31:16]);
               last_in  = req_tlast;
               axis_in  = 1'b0;
               cand_in  = '0;
               best_in  = '1;
               state_in = ST_SCAN;
            end
         end

         // One candidate level per cycle, I axis then Q axis
         ST_SCAN: begin
            best_in     = axis_best;
            best_idx_in = axis_best_idx;
            cand_in     = cand_ff + AXIS_W'(1);
            if (cand_last) begin
               cand_in = '0;
               if (!axis_ff) begin
                  di2_in  = axis_best;
                  ib_in   = axis_best_idx;
                  best_in = '1;
                  axis_in = 1'b1;
               end else begin
                  d2_in    = di2_ff + axis_best;
                  root_in  = '0;
                  bit_in   = SQRT_TOP_BIT;
                  state_in = ST_SQRT;
               end
            end
         end

         // Square root, one result bit per cycle
         ST_SQRT: begin
            if (prod_le) begin
               root_in = root_try;
            end
            bit_in = bit_ff - BIT_W'(1);
            if (bit_ff == '0) begin
               state_in = ST_DONE;
            end
         end

         // Mean of the burst, one quotient bit per cycle
         ST_DIV: begin
            if (prod_le) begin
               quo_in = quo_try;
            end
            bit_in = bit_ff - BIT_W'(1);
            if (bit_ff == '0) begin
               avg_in   = quo_in[MUL_W-1] ? '1 : quo_in[DIST_W-1:0];
               sum_in   = '0;
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end

         // Hand the result to the output register
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {avg_ff, root_ff, bits_out};
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Accumulate distance when the root is complete
      if (state_ff == ST_SQRT && bit_ff == '0) begin
         sum_in = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
         if (cnt_ff < CNT_W'(MAX_BURST)) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
         avg_in = '0;
         if (last_ff) begin
            quo_in   = '0;
            bit_in   = DIV_TOP_BIT;
            state_in = ST_DIV;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_QPSK;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      q_ff        <= q_in;
      last_ff     <= last_in;
      axis_ff     <= axis_in;
      cand_ff     <= cand_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      ib_ff       <= ib_in;
      di2_ff      <= di2_in;
      d2_ff       <= d2_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      quo_ff      <= quo_in;
      avg_ff      <= avg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
